// ===== hw/rtl/mau_pkg.sv =====
// Shared constants, command codes, controller states and status bundle.
package mau_pkg;

    localparam int OperandW = 64;
    localparam int ModW     = 31;
    localparam int CntW     = $clog2(OperandW + 1);

    localparam logic [ModW-1:0] ModReset = 31'd998244353;

    // Operation codes
    localparam logic [3:0] OpReduce = 4'd0;
    localparam logic [3:0] OpAdd    = 4'd1;
    localparam logic [3:0] OpSub    = 4'd2;
    localparam logic [3:0] OpNeg    = 4'd3;
    localparam logic [3:0] OpMul    = 4'd4;
    localparam logic [3:0] OpInv    = 4'd5;
    localparam logic [3:0] OpDiv    = 4'd6;
    localparam logic [3:0] OpPow    = 4'd7;
    localparam logic [3:0] OpEqual  = 4'd8;

    // Datapath commands issued by the controller
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV_A,
        CMD_DIV_B,
        CMD_DIV_PROD,
        CMD_DIV_XY,
        CMD_FIX_A,
        CMD_FIX_B,
        CMD_RES_A,
        CMD_ADD,
        CMD_SUB,
        CMD_NEG,
        CMD_EQ,
        CMD_MUL_AB,
        CMD_MUL_AI,
        CMD_MUL_AC_BS,
        CMD_MUL_BS_BS,
        CMD_MUL_QV,
        CMD_RES_REM,
        CMD_ACC_REM,
        CMD_BASE_REM,
        CMD_EU_INIT_A,
        CMD_EU_INIT_B,
        CMD_EU_UPD,
        CMD_EU_END,
        CMD_PW_INIT,
        CMD_PW_NEG,
        CMD_PUSH
    } t_cmd;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_RA_DIV,
        S_RA_WAIT,
        S_RA_FIX,
        S_RB_DIV,
        S_RB_WAIT,
        S_RB_FIX,
        S_DISPATCH,
        S_M4_MUL,
        S_M6_MUL,
        S_MD_DIV,
        S_MD_WAIT,
        S_MD_WB,
        S_EU_INIT,
        S_EU_TEST,
        S_EU_WAIT,
        S_EU_MUL,
        S_EU_UPD,
        S_EU_END,
        S_PW_INIT,
        S_PW_TEST,
        S_PW_AMUL,
        S_PW_ADIV,
        S_PW_AWAIT,
        S_PW_AWB,
        S_PW_SMUL,
        S_PW_SDIV,
        S_PW_SWAIT,
        S_PW_SWB,
        S_FINISH
    } t_state;

    // Datapath status seen by the controller
    typedef struct packed {
        logic       div_busy;
        logic [3:0] op;
        logic       y_zero;
        logic       x_not_one;
        logic       e_zero;
        logic       e_lsb;
        logic       b_neg;
    } t_status;

endpackage

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// Operand reduction divides each operand by the modulus in turn, then add/sub/neg/equal work on
// the residues, multiply reduces the product, inverse runs extended Euclid steps, divide adds a
// multiply after the inverse, and power squares per clear exponent bit and multiplies and squares
// per set one. The time taken is set by the shared divider, which makes one quotient bit per cycle.
// One item at a time; the next beat is taken once the result is in the output register. Reset
// sets the modulus to 998244353 and drops any item in flight.
module modular_arithmetic_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mau_pkg::ModW-1:0]            i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [3:0]                          i_operation,
    input  logic signed [mau_pkg::OperandW-1:0] i_operand_a,
    input  logic signed [mau_pkg::OperandW-1:0] i_operand_b,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mau_pkg::ModW-1:0]            o_result,
    output logic                                o_is_equal,
    output logic                                o_error
);

    logic [mau_pkg::ModW-1:0] r_modulus;
    logic [mau_pkg::ModW-1:0] mod_act;
    mau_pkg::t_cmd            cmd;
    mau_pkg::t_status         status;

    // Hold the modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mau_pkg::ModReset;
        end else if (i_cfg_wr_en) begin
            r_modulus <= i_cfg_wr_data;
        end
    end

    // A zero modulus acts as one
    assign mod_act = (r_modulus == '0) ? mau_pkg::ModW'(1) : r_modulus;

    mau_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mau_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_modulus   (mod_act),
        .o_status    (status),
        .o_result    (o_result),
        .o_is_equal  (o_is_equal),
        .o_error     (o_error)
    );

endmodule

// ===== hw/rtl/mau_datapath.sv =====
// Datapath: operand registers, bit-serial divider, shared multiplier, result registers.
module mau_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mau_pkg::t_cmd                 i_cmd,
    input  logic [3:0]                    i_operation,
    input  logic signed [mau_pkg::OperandW-1:0] i_operand_a,
    input  logic signed [mau_pkg::OperandW-1:0] i_operand_b,
    input  logic [mau_pkg::ModW-1:0]      i_modulus,
    output mau_pkg::t_status              o_status,
    output logic [mau_pkg::ModW-1:0]      o_result,
    output logic                          o_is_equal,
    output logic                          o_error
);

    localparam int W = mau_pkg::OperandW;
    localparam int M = mau_pkg::ModW;

    // Item registers
    logic [3:0]          r_op;
    logic [W-1:0]        r_amag, r_bmag, r_e, r_prod;
    logic                r_aneg, r_bneg;
    logic [M-1:0]        r_m, r_ra, r_rb, r_res, r_base, r_x, r_y;
    logic                r_eq, r_err;
    logic signed [M+1:0] r_u, r_v;

    // Divider registers
    logic [W-1:0]               r_dvd;
    logic [M-1:0]               r_rem, r_dsr;
    logic [mau_pkg::CntW-1:0]   r_div_cnt;

    // Output beat registers
    logic [M-1:0] r_out_res;
    logic         r_out_eq, r_out_err;

    logic [W-1:0]        a_mag, b_mag;
    logic [M:0]          div_trial, div_sub;
    logic                div_ge;
    logic signed [M:0]   mul_x;
    logic signed [M+1:0] mul_y;
    logic signed [W:0]   mul_p;
    logic [M-1:0]        fix_a, fix_b;
    logic [M:0]          add_sum, add_red;
    logic [M-1:0]        sub_res, neg_res;
    logic signed [M+1:0] m_s, u_fix;

    // Operand magnitudes
    assign a_mag = i_operand_a[W-1] ? (~i_operand_a + W'(1)) : i_operand_a;
    assign b_mag = i_operand_b[W-1] ? (~i_operand_b + W'(1)) : i_operand_b;

    // Divider trial subtract, one quotient bit per cycle
    assign div_trial = {r_rem, r_dvd[W-1]};
    assign div_ge    = div_trial >= {1'b0, r_dsr};
    assign div_sub   = div_trial - {1'b0, r_dsr};

    // Select multiplier operands
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        unique case (i_cmd)
            mau_pkg::CMD_MUL_AB: begin
                mul_x = {1'b0, r_ra};
                mul_y = {2'b00, r_rb};
            end
            mau_pkg::CMD_MUL_AI: begin
                mul_x = {1'b0, r_ra};
                mul_y = {2'b00, r_res};
            end
            mau_pkg::CMD_MUL_AC_BS: begin
                mul_x = {1'b0, r_res};
                mul_y = {2'b00, r_base};
            end
            mau_pkg::CMD_MUL_BS_BS: begin
                mul_x = {1'b0, r_base};
                mul_y = {2'b00, r_base};
            end
            mau_pkg::CMD_MUL_QV: begin
                mul_x = {1'b0, r_dvd[M-1:0]};
                mul_y = r_v;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end
    assign mul_p = mul_x * mul_y;

    // Wrap negative residues
    assign fix_a = (r_aneg && r_rem != '0) ? r_m - r_rem : r_rem;
    assign fix_b = (r_bneg && r_rem != '0) ? r_m - r_rem : r_rem;

    // Short modular operations
    assign add_sum = {1'b0, r_ra} + {1'b0, r_rb};
    assign add_red = (add_sum >= {1'b0, r_m}) ? add_sum - {1'b0, r_m} : add_sum;
    assign sub_res = (r_ra >= r_rb) ? r_ra - r_rb : r_ra + (r_m - r_rb);
    assign neg_res = (r_ra != '0) ? r_m - r_ra : '0;

    // Bring Bezout coefficient into range
    assign m_s   = {2'b00, r_m};
    assign u_fix = (r_u < 0) ? r_u + m_s : ((r_u >= m_s) ? r_u - m_s : r_u);

    // Advance divider count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd == mau_pkg::CMD_DIV_A || i_cmd == mau_pkg::CMD_DIV_B ||
                     i_cmd == mau_pkg::CMD_DIV_PROD || i_cmd == mau_pkg::CMD_DIV_XY) begin
            r_div_cnt <= mau_pkg::CntW'(W);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    // Load or step divider data
    always_ff @(posedge i_clk) begin
        priority if (i_cmd == mau_pkg::CMD_DIV_A) begin
            r_dvd <= r_amag;
            r_dsr <= r_m;
            r_rem <= '0;
        end else if (i_cmd == mau_pkg::CMD_DIV_B) begin
            r_dvd <= r_bmag;
            r_dsr <= r_m;
            r_rem <= '0;
        end else if (i_cmd == mau_pkg::CMD_DIV_PROD) begin
            r_dvd <= r_prod;
            r_dsr <= r_m;
            r_rem <= '0;
        end else if (i_cmd == mau_pkg::CMD_DIV_XY) begin
            r_dvd <= {{(W-M){1'b0}}, r_x};
            r_dsr <= r_y;
            r_rem <= '0;
        end else if (r_div_cnt != '0) begin
            r_rem <= div_ge ? div_sub[M-1:0] : div_trial[M-1:0];
            r_dvd <= {r_dvd[W-2:0], div_ge};
        end
    end

    // Execute datapath commands
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            mau_pkg::CMD_LOAD: begin
                r_op   <= i_operation;
                r_amag <= a_mag;
                r_bmag <= b_mag;
                r_aneg <= i_operand_a[W-1];
                r_bneg <= i_operand_b[W-1];
                r_m    <= i_modulus;
                r_res  <= '0;
                r_eq   <= 1'b0;
                r_err  <= 1'b0;
            end
            mau_pkg::CMD_FIX_A:   r_ra  <= fix_a;
            mau_pkg::CMD_FIX_B:   r_rb  <= fix_b;
            mau_pkg::CMD_RES_A:   r_res <= r_ra;
            mau_pkg::CMD_ADD:     r_res <= add_red[M-1:0];
            mau_pkg::CMD_SUB:     r_res <= sub_res;
            mau_pkg::CMD_NEG:     r_res <= neg_res;
            mau_pkg::CMD_EQ:      r_eq  <= (r_ra == r_rb);
            mau_pkg::CMD_MUL_AB, mau_pkg::CMD_MUL_AI, mau_pkg::CMD_MUL_AC_BS,
            mau_pkg::CMD_MUL_BS_BS, mau_pkg::CMD_MUL_QV: begin
                r_prod <= mul_p[W-1:0];
            end
            mau_pkg::CMD_RES_REM: r_res <= r_rem;
            mau_pkg::CMD_ACC_REM: r_res <= r_rem;
            mau_pkg::CMD_BASE_REM: begin
                r_base <= r_rem;
                r_e    <= r_e >> 1;
            end
            mau_pkg::CMD_EU_INIT_A: begin
                r_x <= r_ra;
                r_y <= r_m;
                r_u <= (M+2)'(1);
                r_v <= '0;
            end
            mau_pkg::CMD_EU_INIT_B: begin
                r_x <= r_rb;
                r_y <= r_m;
                r_u <= (M+2)'(1);
                r_v <= '0;
            end
            mau_pkg::CMD_EU_UPD: begin
                r_x <= r_y;
                r_y <= r_rem;
                r_u <= r_v;
                r_v <= r_u - $signed(r_prod[M+1:0]);
            end
            mau_pkg::CMD_EU_END: begin
                if (r_x != M'(1)) begin
                    r_err <= 1'b1;
                    r_res <= '0;
                end else begin
                    r_res <= u_fix[M-1:0];
                end
            end
            mau_pkg::CMD_PW_INIT: begin
                r_res  <= (r_m == M'(1)) ? '0 : M'(1);
                r_base <= r_ra;
                r_e    <= r_bmag;
            end
            mau_pkg::CMD_PW_NEG:  r_err <= 1'b1;
            mau_pkg::CMD_PUSH: begin
                r_out_res <= r_res;
                r_out_eq  <= r_eq;
                r_out_err <= r_err;
            end
            default: begin
            end
        endcase
    end

    assign o_status.div_busy  = (r_div_cnt != '0);
    assign o_status.op        = r_op;
    assign o_status.y_zero    = (r_y == '0);
    assign o_status.x_not_one = (r_x != M'(1));
    assign o_status.e_zero    = (r_e == '0);
    assign o_status.e_lsb     = r_e[0];
    assign o_status.b_neg     = r_bneg;

    assign o_result   = r_out_res;
    assign o_is_equal = r_out_eq;
    assign o_error    = r_out_err;

endmodule

// ===== hw/rtl/mau_ctrl.sv =====
// Controller: sequences reduction, Euclid, multiply and power steps; owns the handshakes.
module mau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  mau_pkg::t_status i_status,
    output mau_pkg::t_cmd    o_cmd
);

    mau_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mau_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = mau_pkg::CMD_NONE;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            mau_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd   = mau_pkg::CMD_LOAD;
                    n_state = mau_pkg::S_RA_DIV;
                end
            end
            mau_pkg::S_RA_DIV: begin
                o_cmd   = mau_pkg::CMD_DIV_A;
                n_state = mau_pkg::S_RA_WAIT;
            end
            mau_pkg::S_RA_WAIT: begin
                if (!i_status.div_busy) n_state = mau_pkg::S_RA_FIX;
            end
            mau_pkg::S_RA_FIX: begin
                o_cmd   = mau_pkg::CMD_FIX_A;
                n_state = mau_pkg::S_RB_DIV;
            end
            mau_pkg::S_RB_DIV: begin
                o_cmd   = mau_pkg::CMD_DIV_B;
                n_state = mau_pkg::S_RB_WAIT;
            end
            mau_pkg::S_RB_WAIT: begin
                if (!i_status.div_busy) n_state = mau_pkg::S_RB_FIX;
            end
            mau_pkg::S_RB_FIX: begin
                o_cmd   = mau_pkg::CMD_FIX_B;
                n_state = mau_pkg::S_DISPATCH;
            end
            mau_pkg::S_DISPATCH: begin
                n_state = mau_pkg::S_FINISH;
                unique case (i_status.op)
                    mau_pkg::OpReduce: o_cmd = mau_pkg::CMD_RES_A;
                    mau_pkg::OpAdd:    o_cmd = mau_pkg::CMD_ADD;
                    mau_pkg::OpSub:    o_cmd = mau_pkg::CMD_SUB;
                    mau_pkg::OpNeg:    o_cmd = mau_pkg::CMD_NEG;
                    mau_pkg::OpEqual:  o_cmd = mau_pkg::CMD_EQ;
                    mau_pkg::OpMul:    n_state = mau_pkg::S_M4_MUL;
                    mau_pkg::OpInv,
                    mau_pkg::OpDiv:    n_state = mau_pkg::S_EU_INIT;
                    mau_pkg::OpPow:    n_state = mau_pkg::S_PW_INIT;
                    default:           n_state = mau_pkg::S_FINISH;
                endcase
            end
            // Multiply then reduce by the modulus
            mau_pkg::S_M4_MUL: begin
                o_cmd   = mau_pkg::CMD_MUL_AB;
                n_state = mau_pkg::S_MD_DIV;
            end
            mau_pkg::S_M6_MUL: begin
                o_cmd   = mau_pkg::CMD_MUL_AI;
                n_state = mau_pkg::S_MD_DIV;
            end
            mau_pkg::S_MD_DIV: begin
                o_cmd   = mau_pkg::CMD_DIV_PROD;
                n_state = mau_pkg::S_MD_WAIT;
            end
            mau_pkg::S_MD_WAIT: begin
                if (!i_status.div_busy) n_state = mau_pkg::S_MD_WB;
            end
            mau_pkg::S_MD_WB: begin
                o_cmd   = mau_pkg::CMD_RES_REM;
                n_state = mau_pkg::S_FINISH;
            end
            // Extended Euclid
            mau_pkg::S_EU_INIT: begin
                o_cmd   = (i_status.op == mau_pkg::OpDiv) ? mau_pkg::CMD_EU_INIT_B
                                                          : mau_pkg::CMD_EU_INIT_A;
                n_state = mau_pkg::S_EU_TEST;
            end
            mau_pkg::S_EU_TEST: begin
                if (i_status.y_zero) begin
                    n_state = mau_pkg::S_EU_END;
                end else begin
                    o_cmd   = mau_pkg::CMD_DIV_XY;
                    n_state = mau_pkg::S_EU_WAIT;
                end
            end
            mau_pkg::S_EU_WAIT: begin
                if (!i_status.div_busy) n_state = mau_pkg::S_EU_MUL;
            end
            mau_pkg::S_EU_MUL: begin
                o_cmd   = mau_pkg::CMD_MUL_QV;
                n_state = mau_pkg::S_EU_UPD;
            end
            mau_pkg::S_EU_UPD: begin
                o_cmd   = mau_pkg::CMD_EU_UPD;
                n_state = mau_pkg::S_EU_TEST;
            end
            mau_pkg::S_EU_END: begin
                o_cmd = mau_pkg::CMD_EU_END;
                if (!i_status.x_not_one && i_status.op == mau_pkg::OpDiv) begin
                    n_state = mau_pkg::S_M6_MUL;
                end else begin
                    n_state = mau_pkg::S_FINISH;
                end
            end
            // Square and multiply
            mau_pkg::S_PW_INIT: begin
                if (i_status.b_neg) begin
                    o_cmd   = mau_pkg::CMD_PW_NEG;
                    n_state = mau_pkg::S_FINISH;
                end else begin
                    o_cmd   = mau_pkg::CMD_PW_INIT;
                    n_state = mau_pkg::S_PW_TEST;
                end
            end
            mau_pkg::S_PW_TEST: begin
                priority if (i_status.e_zero) n_state = mau_pkg::S_FINISH;
                else if (i_status.e_lsb)      n_state = mau_pkg::S_PW_AMUL;
                else                          n_state = mau_pkg::S_PW_SMUL;
            end
            mau_pkg::S_PW_AMUL: begin
                o_cmd   = mau_pkg::CMD_MUL_AC_BS;
                n_state = mau_pkg::S_PW_ADIV;
            end
            mau_pkg::S_PW_ADIV: begin
                o_cmd   = mau_pkg::CMD_DIV_PROD;
                n_state = mau_pkg::S_PW_AWAIT;
            end
            mau_pkg::S_PW_AWAIT: begin
                if (!i_status.div_busy) n_state = mau_pkg::S_PW_AWB;
            end
            mau_pkg::S_PW_AWB: begin
                o_cmd   = mau_pkg::CMD_ACC_REM;
                n_state = mau_pkg::S_PW_SMUL;
            end
            mau_pkg::S_PW_SMUL: begin
                o_cmd   = mau_pkg::CMD_MUL_BS_BS;
                n_state = mau_pkg::S_PW_SDIV;
            end
            mau_pkg::S_PW_SDIV: begin
                o_cmd   = mau_pkg::CMD_DIV_PROD;
                n_state = mau_pkg::S_PW_SWAIT;
            end
            mau_pkg::S_PW_SWAIT: begin
                if (!i_status.div_busy) n_state = mau_pkg::S_PW_SWB;
            end
            mau_pkg::S_PW_SWB: begin
                o_cmd   = mau_pkg::CMD_BASE_REM;
                n_state = mau_pkg::S_PW_TEST;
            end
            // Push the result beat once the output register is free
            mau_pkg::S_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd       = mau_pkg::CMD_PUSH;
                    n_out_valid = 1'b1;
                    n_state     = mau_pkg::S_IDLE;
                end
            end
            default: n_state = mau_pkg::S_IDLE;
        endcase
    end

    assign o_stall = (r_state != mau_pkg::S_IDLE);
    assign o_valid = r_out_valid;

endmodule
